// ===== rtl/aesc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aesc_pkg
// Shared types and constants of the expression syntax checker.
// ----------------------------------------------------------------------------
package aesc_pkg;

    localparam int unsigned DEFAULT_MAX_DEPTH = 255;
    localparam int unsigned OP_EN_W           = 6;
    localparam logic [OP_EN_W-1:0] OP_EN_RESET = 6'd15;

    localparam logic [7:0] CH_OPEN    = 8'h28;
    localparam logic [7:0] CH_CLOSE   = 8'h29;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam int unsigned OPB_PLUS    = 0;
    localparam int unsigned OPB_MINUS   = 1;
    localparam int unsigned OPB_STAR    = 2;
    localparam int unsigned OPB_SLASH   = 3;
    localparam int unsigned OPB_PERCENT = 4;
    localparam int unsigned OPB_CARET   = 5;

    typedef enum logic [3:0] {
        ST_PENDING      = 4'd0,
        ST_ACCEPTED     = 4'd1,
        ST_EMPTY_LINE   = 4'd2,
        ST_BLANK        = 4'd3,
        ST_START_CLOSE  = 4'd4,
        ST_START_OP     = 4'd5,
        ST_START_UNK    = 4'd6,
        ST_AFTER_NUM    = 4'd7,
        ST_END_OP       = 4'd8,
        ST_AFTER_OP     = 4'd9,
        ST_END_OPEN     = 4'd10,
        ST_AFTER_OPEN   = 4'd11,
        ST_MISSING_OPEN = 4'd12,
        ST_AFTER_CLOSE  = 4'd13,
        ST_MISSING_CLS  = 4'd14,
        ST_OVERFLOW     = 4'd15
    } t_status;

    typedef enum logic [2:0] {
        M_EMPTY,
        M_BLANK,
        M_AFTER_OP,
        M_AFTER_OPEN,
        M_IN_NUM,
        M_AFTER_NUM,
        M_AFTER_CLOSE,
        M_MINUS
    } t_mode;

    typedef enum logic [1:0] {
        CTX_NONE,
        CTX_START,
        CTX_OP,
        CTX_OPEN
    } t_ctx;

    typedef struct packed {
        logic is_space;
        logic is_digit;
        logic is_op;
        logic is_minus;
        logic is_open;
        logic is_close;
    } t_char_class;

endpackage

`default_nettype wire

// ===== rtl/arithmetic_expression_syntax_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arithmetic_expression_syntax_checker
// An accepted item passes the input register, then the result register.
// Throughput: one item per cycle while i_m_tready is high; the parse state
// update is a single register-to-register step; items may follow every cycle.
// Reset: synchronous, active low; clears the line state, both pipeline
// valid flags, and restores the operator mask to plus, minus, star, slash.
// ----------------------------------------------------------------------------
// Structure: an input register holds the accepted item; the character is
// classified and the parse state is advanced in the same cycle in which the
// item moves into the result register. The result register only loads when
// it is empty or being drained, so the state update is tied to the result
// slot and no result is ever lost. The input register acts as the skid
// stage, so the block can take one more item while a finished result waits.
// ----------------------------------------------------------------------------
module arithmetic_expression_syntax_checker #(
    parameter int unsigned MAX_DEPTH = aesc_pkg::DEFAULT_MAX_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Operator enable register: plus, minus, star, slash, percent, caret.
    input  wire logic        i_cfg_we,
    input  wire logic [5:0]  i_cfg_wdata,
    // Input item stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] ch
    input  wire logic        i_s_tuser,   // [0] kind (1 = end of line)
    // Result item stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata    // [3:0] status, [11:4] nesting_depth, [15:12] zero
);

    logic [aesc_pkg::OP_EN_W-1:0] r_op_en;

    logic       r_s1_valid;
    logic       r_s1_kind;
    logic [7:0] r_s1_ch;

    logic              r_out_valid;
    aesc_pkg::t_status r_out_status;
    logic [7:0]        r_out_depth;

    logic                  w_advance;
    aesc_pkg::t_char_class w_class;
    aesc_pkg::t_status     w_status;
    logic [7:0]            w_depth;

    // The staged item moves on when the result slot is free or draining.
    assign w_advance  = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_en <= aesc_pkg::OP_EN_RESET;
        end else if (i_cfg_we) begin
            r_op_en <= i_cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_s1_kind <= i_s_tuser;
            r_s1_ch   <= i_s_tdata;
        end
    end

    aesc_char_class u_class (
        .i_ch    (r_s1_ch),
        .i_op_en (r_op_en),
        .o_class (w_class)
    );

    aesc_parse_core #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_advance),
        .i_eol      (r_s1_kind),
        .i_class    (w_class),
        .i_minus_en (r_op_en[aesc_pkg::OPB_MINUS]),
        .o_status   (w_status),
        .o_depth    (w_depth)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_status <= w_status;
            r_out_depth  <= w_depth;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_depth, r_out_status};

    // An accepted line always closes every parenthesis it opened.
    a_accept_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == aesc_pkg::ST_ACCEPTED)) |-> (r_out_depth == 8'd0))
        else $error("accepted result with open parentheses");

    // Back pressure only when both the staged item and the result are held.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_s1_valid && r_out_valid && !i_m_tready))
        else $error("input stalled while a stage is free");

    // A staged item that cannot advance keeps its character.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_advance) |=> (r_s1_valid && $stable(r_s1_ch) && $stable(r_s1_kind)))
        else $error("staged item lost while stalled");

endmodule

`default_nettype wire

// ===== rtl/aesc_char_class.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aesc_char_class
// Sorts one character byte into the classes the parser needs.
// ----------------------------------------------------------------------------
module aesc_char_class (
    input  wire logic [7:0]                    i_ch,
    input  wire logic [aesc_pkg::OP_EN_W-1:0]  i_op_en,
    output aesc_pkg::t_char_class              o_class
);

    logic w_op;

    always_comb begin
        unique case (i_ch)
            aesc_pkg::CH_PLUS:    w_op = i_op_en[aesc_pkg::OPB_PLUS];
            aesc_pkg::CH_MINUS:   w_op = i_op_en[aesc_pkg::OPB_MINUS];
            aesc_pkg::CH_STAR:    w_op = i_op_en[aesc_pkg::OPB_STAR];
            aesc_pkg::CH_SLASH:   w_op = i_op_en[aesc_pkg::OPB_SLASH];
            aesc_pkg::CH_PERCENT: w_op = i_op_en[aesc_pkg::OPB_PERCENT];
            aesc_pkg::CH_CARET:   w_op = i_op_en[aesc_pkg::OPB_CARET];
            default:              w_op = 1'b0;
        endcase
    end

    always_comb begin
        o_class.is_space = (i_ch == aesc_pkg::CH_SPACE) ||
                           ((i_ch >= aesc_pkg::CH_TAB) && (i_ch <= aesc_pkg::CH_CR));
        o_class.is_digit = (i_ch >= aesc_pkg::CH_ZERO) && (i_ch <= aesc_pkg::CH_NINE);
        o_class.is_op    = w_op;
        o_class.is_minus = (i_ch == aesc_pkg::CH_MINUS);
        o_class.is_open  = (i_ch == aesc_pkg::CH_OPEN);
        o_class.is_close = (i_ch == aesc_pkg::CH_CLOSE);
    end

endmodule

`default_nettype wire

// ===== rtl/aesc_parse_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aesc_parse_core
// Line parse state: token mode, paren depth, latched error, held minus.
// ----------------------------------------------------------------------------
module aesc_parse_core #(
    parameter int unsigned MAX_DEPTH = aesc_pkg::DEFAULT_MAX_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_eol,
    input  wire aesc_pkg::t_char_class         i_class,
    input  wire logic                          i_minus_en,
    output aesc_pkg::t_status                  o_status,
    output logic [7:0]                         o_depth
);

    localparam int unsigned DW = $clog2(MAX_DEPTH + 1);

    aesc_pkg::t_mode   r_mode, n_mode;
    aesc_pkg::t_ctx    r_ctx, n_ctx;
    aesc_pkg::t_status r_err, n_err;
    logic [DW-1:0]     r_depth, n_depth;

    aesc_pkg::t_status w_err;
    aesc_pkg::t_status w_minus_err;
    aesc_pkg::t_status w_end;
    logic              w_operand;
    logic              w_full;
    logic [16:0]       w_depth_ext;

    assign w_operand = (r_mode == aesc_pkg::M_EMPTY) || (r_mode == aesc_pkg::M_BLANK) ||
                       (r_mode == aesc_pkg::M_AFTER_OP) || (r_mode == aesc_pkg::M_AFTER_OPEN);
    assign w_full    = (r_depth >= DW'(MAX_DEPTH));

    // Error for a held minus that is not followed by a digit.
    always_comb begin
        unique case (r_ctx)
            aesc_pkg::CTX_OP:   w_minus_err = aesc_pkg::ST_AFTER_OP;
            aesc_pkg::CTX_OPEN: w_minus_err = aesc_pkg::ST_AFTER_OPEN;
            default: w_minus_err = i_minus_en ? aesc_pkg::ST_START_OP
                                              : aesc_pkg::ST_START_UNK;
        endcase
    end

    // Error raised by the current character (pending when it is fine).
    always_comb begin
        w_err = aesc_pkg::ST_PENDING;
        if (r_mode == aesc_pkg::M_MINUS) begin
            if (!i_class.is_digit) w_err = w_minus_err;
        end else if (w_operand) begin
            priority if (i_class.is_space || i_class.is_digit || i_class.is_minus) begin
                w_err = aesc_pkg::ST_PENDING;
            end else if (i_class.is_open) begin
                if (w_full) w_err = aesc_pkg::ST_OVERFLOW;
            end else if (r_mode == aesc_pkg::M_AFTER_OP) begin
                w_err = aesc_pkg::ST_AFTER_OP;
            end else if (r_mode == aesc_pkg::M_AFTER_OPEN) begin
                w_err = aesc_pkg::ST_AFTER_OPEN;
            end else if (i_class.is_close) begin
                w_err = aesc_pkg::ST_START_CLOSE;
            end else if (i_class.is_op) begin
                w_err = aesc_pkg::ST_START_OP;
            end else begin
                w_err = aesc_pkg::ST_START_UNK;
            end
        end else begin
            priority if (i_class.is_space) begin
                w_err = aesc_pkg::ST_PENDING;
            end else if ((r_mode == aesc_pkg::M_IN_NUM) && i_class.is_digit) begin
                w_err = aesc_pkg::ST_PENDING;
            end else if (i_class.is_op) begin
                w_err = aesc_pkg::ST_PENDING;
            end else if (i_class.is_close) begin
                if (r_depth == '0) w_err = aesc_pkg::ST_MISSING_OPEN;
            end else if (r_mode == aesc_pkg::M_AFTER_CLOSE) begin
                w_err = aesc_pkg::ST_AFTER_CLOSE;
            end else begin
                w_err = aesc_pkg::ST_AFTER_NUM;
            end
        end
    end

    // Verdict at end of line when no error was latched.
    always_comb begin
        unique case (r_mode)
            aesc_pkg::M_EMPTY:      w_end = aesc_pkg::ST_EMPTY_LINE;
            aesc_pkg::M_BLANK:      w_end = aesc_pkg::ST_BLANK;
            aesc_pkg::M_AFTER_OP:   w_end = aesc_pkg::ST_END_OP;
            aesc_pkg::M_AFTER_OPEN: w_end = aesc_pkg::ST_END_OPEN;
            aesc_pkg::M_MINUS:      w_end = w_minus_err;
            default: w_end = (r_depth != '0) ? aesc_pkg::ST_MISSING_CLS
                                             : aesc_pkg::ST_ACCEPTED;
        endcase
    end

    // Next state. Error paths leave mode, depth and context untouched.
    always_comb begin
        n_mode  = r_mode;
        n_ctx   = r_ctx;
        n_depth = r_depth;
        n_err   = r_err;
        if (i_eol) begin
            n_mode  = aesc_pkg::M_EMPTY;
            n_ctx   = aesc_pkg::CTX_NONE;
            n_depth = '0;
            n_err   = aesc_pkg::ST_PENDING;
        end else if (r_err == aesc_pkg::ST_PENDING) begin
            n_err = w_err;
            if (w_err == aesc_pkg::ST_PENDING) begin
                if (r_mode == aesc_pkg::M_MINUS) begin
                    n_mode = aesc_pkg::M_IN_NUM;
                    n_ctx  = aesc_pkg::CTX_NONE;
                end else if (w_operand) begin
                    priority if (i_class.is_space) begin
                        if (r_mode == aesc_pkg::M_EMPTY) n_mode = aesc_pkg::M_BLANK;
                    end else if (i_class.is_digit) begin
                        n_mode = aesc_pkg::M_IN_NUM;
                    end else if (i_class.is_minus) begin
                        n_mode = aesc_pkg::M_MINUS;
                        unique case (r_mode)
                            aesc_pkg::M_AFTER_OP:   n_ctx = aesc_pkg::CTX_OP;
                            aesc_pkg::M_AFTER_OPEN: n_ctx = aesc_pkg::CTX_OPEN;
                            default:                n_ctx = aesc_pkg::CTX_START;
                        endcase
                    end else if (i_class.is_open) begin
                        n_mode  = aesc_pkg::M_AFTER_OPEN;
                        n_depth = r_depth + DW'(1);
                    end else begin
                        n_mode = r_mode;
                    end
                end else begin
                    priority if (i_class.is_space) begin
                        if (r_mode == aesc_pkg::M_IN_NUM) n_mode = aesc_pkg::M_AFTER_NUM;
                    end else if ((r_mode == aesc_pkg::M_IN_NUM) && i_class.is_digit) begin
                        n_mode = r_mode;
                    end else if (i_class.is_op) begin
                        n_mode = aesc_pkg::M_AFTER_OP;
                    end else if (i_class.is_close) begin
                        n_mode  = aesc_pkg::M_AFTER_CLOSE;
                        n_depth = r_depth - DW'(1);
                    end else begin
                        n_mode = r_mode;
                    end
                end
            end
        end
    end

    // Result of this item.
    always_comb begin
        if (i_eol) begin
            o_status    = (r_err != aesc_pkg::ST_PENDING) ? r_err : w_end;
            w_depth_ext = 17'(r_depth);
        end else begin
            o_status    = n_err;
            w_depth_ext = 17'(n_depth);
        end
        o_depth = (w_depth_ext > 17'd255) ? 8'hFF : w_depth_ext[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= aesc_pkg::M_EMPTY;
            r_ctx   <= aesc_pkg::CTX_NONE;
            r_depth <= '0;
            r_err   <= aesc_pkg::ST_PENDING;
        end else if (i_en) begin
            r_mode  <= n_mode;
            r_ctx   <= n_ctx;
            r_depth <= n_depth;
            r_err   <= n_err;
        end
    end

endmodule

`default_nettype wire
